@@ rtl/column_projection_run_segmenter_macros.svh @@
// Assertion macros used by the column projection run segmenter datapath.
`ifndef COLUMN_PROJECTION_RUN_SEGMENTER_MACROS_SVH
`define COLUMN_PROJECTION_RUN_SEGMENTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CPRS_ASSERT_NOW(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CPRS_ASSERT_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cprs_pkg.sv @@
// Shared types and constants of the column projection run segmenter.
`default_nettype none
package cprs_pkg;

  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INK_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_WIDTH = 2'd2;

  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST   = 9'd256;
  localparam logic [CFG_DATA_W-1:0] INK_THRESHOLD_RST = 9'd200;
  localparam logic [CFG_DATA_W-1:0] MIN_RUN_WIDTH_RST = 9'd3;

  // Runs reported per image at most.
  localparam int MAX_RESULTS = 64;
  localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_CLOSE,
    ST_FINAL
  } cprs_state_t;

  typedef struct packed {
    logic init_clear;
    logic pixel_take;
    logic scan_step;
    logic close_step;
    logic final_step;
  } cprs_cmd_t;

  typedef struct packed {
    logic init_last;
    logic scan_done;
    logic out_free;
  } cprs_status_t;

endpackage
`default_nettype wire

@@ rtl/column_projection_run_segmenter.sv @@
// Top level: vertical projection character segmenter (pixel stream in, column runs out).
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  config   | cfg_we                | cfg_index, cfg_data (9 bits)
//  pixel in | in_valid / in_ready   | red, green, blue, frame_end
//  run out  | out_valid / out_ready | run_start, run_end, run_found, last_run
//
//  Pixels: one transaction per cycle while idle; each ink pixel sets its column flag.
//  Frame end: after the frame_end pixel the flag memory is swept once, one column
//    read (and cleared) per cycle while the sweep is not stalled.
//  Reset: a clearing pass over all MAX_COLUMNS columns runs first; no pixel is taken
//    until it ends, config writes are taken throughout.
//  Stalls: a full output register that is not being drained halts the sweep.
`default_nettype none
module column_projection_run_segmenter #(
  parameter int MAX_COLUMNS = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // config write port
  input  wire logic                             cfg_we,
  input  wire logic [cprs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cprs_pkg::CFG_DATA_W-1:0]  cfg_data,
  // pixel stream
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       red,
  input  wire logic [7:0]                       green,
  input  wire logic [7:0]                       blue,
  input  wire logic                             frame_end,
  // run results
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [7:0]                            run_start,
  output logic [7:0]                            run_end,
  output logic                                  run_found,
  output logic                                  last_run
);
  import cprs_pkg::*;

  // Controller drives commands, datapath reports status back.
  cprs_cmd_t    cmd;
  cprs_status_t status;

  cprs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .frame_end (frame_end),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath holds the flag memory, the run tracker and the output register,
  // so a finished result waits there while the next pixels keep flowing.
  cprs_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .frame_end (frame_end),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .run_start (run_start),
    .run_end   (run_end),
    .run_found (run_found),
    .last_run  (last_run),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

@@ rtl/cprs_datapath.sv @@
// Datapath: config registers, column flag memory, scan pipeline, run tracking, output register.
`default_nettype none
`include "column_projection_run_segmenter_macros.svh"
module cprs_datapath #(
  parameter int MAX_COLUMNS = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [cprs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cprs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [7:0]                       red,
  input  wire logic [7:0]                       green,
  input  wire logic [7:0]                       blue,
  input  wire logic                             frame_end,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic [7:0]                            run_start,
  output logic [7:0]                            run_end,
  output logic                                  run_found,
  output logic                                  last_run,
  input  wire cprs_pkg::cprs_cmd_t              cmd,
  output cprs_pkg::cprs_status_t                status
);
  import cprs_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int WW = CW + 1;
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLUMNS - 1);
  localparam logic [CFG_DATA_W-1:0] MAX_CFG = CFG_DATA_W'(MAX_COLUMNS);

  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] ink_threshold;
  logic [CFG_DATA_W-1:0] min_run_width;

  logic [WW-1:0] eff_width;
  logic [9:0]    pix_sum;
  logic [10:0]   thr3;
  logic          pix_ink;
  logic [CW-1:0] column_pos;
  logic [CW-1:0] pos_eff;
  logic [WW-1:0] pos_inc;
  logic [CW-1:0] pos_wrap;

  logic          col_mem [MAX_COLUMNS];
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic          mem_wdata;
  logic          mem_re;
  logic          rd_ink;

  logic [CW-1:0] addr;
  logic          issue_done;
  logic          rd_valid;
  logic [CW-1:0] rd_col;

  logic          open;
  logic [CW-1:0] start;
  logic          pend_valid;
  logic [CW-1:0] pend_start;
  logic [CW-1:0] pend_end;
  logic [COUNT_W-1:0] count;

  logic          ink_c;
  logic          close_req;
  logic [CW-1:0] close_end;
  logic [8:0]    run_len;
  logic          qualifies;
  logic          push;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IMAGE_WIDTH_RST;
      ink_threshold <= INK_THRESHOLD_RST;
      min_run_width <= MIN_RUN_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_INK_THRESHOLD: ink_threshold <= cfg_data;
        REG_MIN_RUN_WIDTH: min_run_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // Width clamped to 1..MAX_COLUMNS
  always_comb begin
    if (image_width == '0) begin
      eff_width = WW'(1);
    end else if (image_width > MAX_CFG) begin
      eff_width = WW'(MAX_COLUMNS);
    end else begin
      eff_width = WW'(image_width);
    end
  end

  // floor(sum/3) < thr  <=>  sum < 3*thr
  assign pix_sum = 10'(red) + 10'(green) + 10'(blue);
  assign thr3    = {1'b0, ink_threshold, 1'b0} + 11'(ink_threshold);
  assign pix_ink = 11'(pix_sum) < thr3;

  assign pos_eff  = ({1'b0, column_pos} >= eff_width) ? '0 : column_pos;
  assign pos_inc  = WW'(pos_eff) + WW'(1);
  assign pos_wrap = (pos_inc >= eff_width) ? '0 : pos_inc[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
    end else if (cmd.pixel_take) begin
      column_pos <= frame_end ? '0 : pos_wrap;
    end
  end

  // Flag memory: set by ink pixels, cleared by the init pass and by the scan
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = 1'b0;
    if (cmd.pixel_take && pix_ink) begin
      mem_we    = 1'b1;
      mem_waddr = pos_eff;
      mem_wdata = 1'b1;
    end else if (cmd.init_clear || (cmd.scan_step && !issue_done)) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = cmd.scan_step && !issue_done;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      col_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_ink <= col_mem[addr];
    end
  end

  // Sweep address and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      issue_done <= 1'b1;
      rd_valid   <= 1'b0;
    end else begin
      if (cmd.init_clear) begin
        addr <= (addr == COL_LAST) ? '0 : addr + CW'(1);
      end
      if (cmd.pixel_take && frame_end) begin
        addr       <= '0;
        issue_done <= 1'b0;
        rd_valid   <= 1'b0;
      end
      if (cmd.scan_step) begin
        rd_valid <= !issue_done;
        if (!issue_done) begin
          addr       <= (addr == COL_LAST) ? '0 : addr + CW'(1);
          issue_done <= (addr == COL_LAST);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_col <= addr;
    end
  end

  assign status.init_last = (addr == COL_LAST);
  assign status.scan_done = issue_done && !rd_valid;
  assign status.out_free  = !out_valid || out_ready;

  // Columns at or past the width read as blank, so a run reaching the
  // last column closes on the first column beyond it, or at the close step at full width.
  assign ink_c = rd_ink && ({1'b0, rd_col} < eff_width);

  always_comb begin
    close_req = 1'b0;
    close_end = rd_col - CW'(1);
    if (cmd.scan_step && rd_valid && !ink_c && open) begin
      close_req = 1'b1;
    end else if (cmd.close_step && open) begin
      close_req = 1'b1;
      close_end = CW'(eff_width - WW'(1));
    end
  end

  assign run_len   = 9'(close_end) - 9'(start) + 9'd1;
  assign qualifies = close_req && (run_len >= min_run_width)
                     && (count < COUNT_W'(MAX_RESULTS));
  assign push      = (qualifies && pend_valid) || cmd.final_step;

  // Run tracking; the newest qualifying run waits in pend_* until it is
  // known whether it is the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      open       <= 1'b0;
      pend_valid <= 1'b0;
      count      <= '0;
    end else begin
      if (cmd.scan_step && rd_valid) begin
        if (ink_c && !open) begin
          open <= 1'b1;
        end else if (!ink_c && open) begin
          open <= 1'b0;
        end
      end
      if (cmd.close_step) begin
        open <= 1'b0;
      end
      if (qualifies) begin
        pend_valid <= 1'b1;
        count      <= count + COUNT_W'(1);
      end
      if (cmd.final_step) begin
        pend_valid <= 1'b0;
        count      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && rd_valid && ink_c && !open) begin
      start <= rd_col;
    end
    if (qualifies) begin
      pend_start <= start;
      pend_end   <= close_end;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.final_step) begin
      run_start <= pend_valid ? 8'(pend_start) : 8'd0;
      run_end   <= pend_valid ? 8'(pend_end) : 8'd0;
      run_found <= pend_valid;
      last_run  <= 1'b1;
    end else if (qualifies && pend_valid) begin
      run_start <= 8'(pend_start);
      run_end   <= 8'(pend_end);
      run_found <= 1'b1;
      last_run  <= 1'b0;
    end
  end

  `CPRS_ASSERT_NOW(a_pixel_excl, clk, rst, cmd.pixel_take, !(cmd.scan_step || cmd.init_clear || cmd.close_step || cmd.final_step), "pixel taken during sweep")
  `CPRS_ASSERT_NOW(a_push_free, clk, rst, push, !out_valid || out_ready, "result overwritten")
  `CPRS_ASSERT_NOW(a_pend_count, clk, rst, pend_valid, count != '0, "pending run not counted")
  `CPRS_ASSERT_NEXT(a_final_clean, clk, rst, cmd.final_step, !pend_valid && !open && count == '0, "run state left after frame")

endmodule
`default_nettype wire

@@ rtl/cprs_ctrl.sv @@
// Controller: sequences init clear, pixel intake, column scan and result flush.
`default_nettype none
module cprs_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  frame_end,
  output logic                       in_ready,
  output cprs_pkg::cprs_cmd_t        cmd,
  input  wire cprs_pkg::cprs_status_t status
);
  import cprs_pkg::*;

  cprs_state_t state;
  cprs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (status.init_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && frame_end) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_CLOSE;
      end
      ST_CLOSE: begin
        if (status.out_free) state_next = ST_FINAL;
      end
      ST_FINAL: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_INIT: begin
        cmd.init_clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.pixel_take = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_step = !status.scan_done && status.out_free;
      end
      ST_CLOSE: begin
        cmd.close_step = status.out_free;
      end
      ST_FINAL: begin
        cmd.final_step = status.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the column projection run segmenter.
`timescale 1ns / 100ps

module testbench;
  import cprs_pkg::*;

  localparam int COLUMNS = 256;
  // Wait long enough for the sweep after a frame end, with some slack on top.
  localparam int SWEEP_CYCLES = COLUMNS + 11;
  // Cycles without any transaction before the run is declared hung. Covers
  // the clearing pass after reset, one sweep and a settle pause.
  localparam int WATCHDOG = 4000;
  // Directed rows plus about 460 random pixels.
  localparam int PIXEL_BUDGET = 485;

  // One run item as the block reports it.
  typedef struct packed {
    logic [7:0] first_col;
    logic [7:0] last_col;
    logic       found;
    logic       closing;
  } run_t;

  // One row of the directed table: a register write or a pixel. A pinned
  // pixel carries its single result item, typed in by hand.
  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [7:0]            red_v;
    logic [7:0]            green_v;
    logic [7:0]            blue_v;
    logic                  last_px;
    logic                  pinned;
    run_t                  pinned_run;
  } plan_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [7:0]            red       = '0;
  logic [7:0]            green     = '0;
  logic [7:0]            blue      = '0;
  logic                  frame_end = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            run_start;
  logic [7:0]            run_end;
  logic                  run_found;
  logic                  last_run;

  // Hand-typed expectation riding along with the pixel that is on the bus.
  logic pin_on  = 1'b0;
  run_t pin_run = '0;

  column_projection_run_segmenter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .frame_end (frame_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .run_start (run_start),
    .run_end   (run_end),
    .run_found (run_found),
    .last_run  (last_run)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Projection model: register copies, column flags and write position.
  // ---------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] width_reg  = IMAGE_WIDTH_RST;
  logic [CFG_DATA_W-1:0] thresh_reg = INK_THRESHOLD_RST;
  logic [CFG_DATA_W-1:0] min_reg    = MIN_RUN_WIDTH_RST;
  bit                    inked [COLUMNS];
  int unsigned           col_pos = 0;

  run_t latest_runs [$];   // runs caused by the pixel just projected
  run_t pending_runs [$];  // runs still owed by the block, oldest first

  int unsigned pixels_sent = 0;
  int unsigned runs_checked = 0;
  int unsigned frames_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned failures = 0;
  bit          calm = 1'b0;    // no idling on either side while set
  bit          dirty = 1'b0;   // pixels went in since the last settle

  // Width register clamped to 1..COLUMNS.
  function automatic int unsigned eff_cols(logic [CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > COLUMNS) return COLUMNS;
    return v;
  endfunction

  // Fold one pixel into the column flags; on frame end sweep the columns
  // and leave the reported runs in latest_runs.
  function automatic void project_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic fe);
    int unsigned w, pos, mean, x, first;
    bit          run_open, ink;
    run_t        item;
    w = eff_cols(width_reg);
    pos = col_pos;
    latest_runs = {};
    // position left past a narrowed width restarts at column 0
    if (pos >= w) pos = 0;
    mean = (int'(r) + int'(g) + int'(b)) / 3;
    if (mean < thresh_reg) inked[pos] = 1'b1;
    pos++;
    col_pos = (pos >= w) ? 0 : pos;
    if (!fe) return;

    // x == w acts as a blank column so that a run open at the edge closes.
    run_open = 1'b0;
    first = 0;
    for (x = 0; x <= w; x++) begin
      ink = (x < w) ? inked[x] : 1'b0;
      if (ink && !run_open) begin
        run_open = 1'b1;
        first = x;
      end else if (!ink && run_open) begin
        run_open = 1'b0;
        if (latest_runs.size() < MAX_RESULTS && (x - first) >= min_reg) begin
          item = '{first_col: first[7:0], last_col: 8'(x - 1), found: 1'b1,
                   closing: 1'b0};
          latest_runs.push_back(item);
        end
      end
    end
    if (latest_runs.size() == 0) begin
      latest_runs.push_back('{first_col: 8'd0, last_col: 8'd0, found: 1'b0,
                              closing: 1'b1});
    end else begin
      latest_runs[$].closing = 1'b1;
    end
    foreach (inked[i]) inked[i] = 1'b0;
    col_pos = 0;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the edge's
  // nonblocking updates land, so the order of processes does not matter.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    run_t want;
    if (!rst) begin
      if (cfg_we) begin
        reg_writes++;
        case (cfg_index)
          REG_IMAGE_WIDTH:   width_reg  = cfg_data;
          REG_INK_THRESHOLD: thresh_reg = cfg_data;
          REG_MIN_RUN_WIDTH: min_reg    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        project_pixel(red, green, blue, frame_end);
        if (frame_end) frames_seen++;
        // a pinned row replaces the projected item by the typed one
        if (pin_on) pending_runs.push_back(pin_run);
        else foreach (latest_runs[i]) pending_runs.push_back(latest_runs[i]);
      end
      if (out_valid && out_ready) begin
        runs_checked++;
        if (pending_runs.size() == 0) begin
          $error("run item with nothing expected: start %0d end %0d found %0d last %0d",
                 run_start, run_end, run_found, last_run);
          failures++;
        end else begin
          want = pending_runs.pop_front();
          check_field("run_start", want.first_col, run_start);
          check_field("run_end", want.last_col, run_end);
          check_field("run_found", want.found, run_found);
          check_field("last_run", want.closing, last_run);
        end
      end
    end
  end

  // Receiver: stalls with a chance of about 8 in a hundred, never while calm.
  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 8);

  // Watchdog on cycles without any transaction.
  int unsigned quiet = 0;
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet == WATCHDOG) begin
      $display("watchdog: %0d idle cycles, %0d runs outstanding", quiet,
               pending_runs.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Drivers. All tasks return right after a rising edge.
  // ---------------------------------------------------------------------
  // Offer one pixel after a random gap and hold it until it is taken.
  task automatic drive_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe,
                             logic pin = 1'b0, run_t pr = '0);
    int unsigned gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 8) gap++;
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    red       <= r;
    green     <= g;
    blue      <= b;
    frame_end <= fe;
    pin_on    <= pin;
    pin_run   <= pr;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    dirty = 1'b1;
  endtask

  // Let every owed run drain and the sweep finish before touching registers.
  // Before that it lets the monitor book the pixel just taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (SWEEP_CYCLES) @(posedge clk);
    dirty = 1'b0;
  endtask

  // Leaves cfg_we high; the next pixel lowers it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (dirty) settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  function automatic logic [7:0] shade(bit dark);
    return dark ? 8'($urandom_range(0, 100)) : 8'($urandom_range(150, 255));
  endfunction

  // Image of rows x cols with inked column blocks. Some images get cut
  // short, either closed early or left open into the next image or phase.
  task automatic random_frame(int unsigned cols, int unsigned rows);
    bit          dark_col [COLUMNS];
    bit          dark, closed, ink;
    int unsigned total, stop, n;
    dark = 1'($urandom_range(1));
    for (int c = 0; c < cols; c++) begin
      if ($urandom_range(99) < 30) dark = !dark;
      dark_col[c] = dark;
    end
    total = rows * cols;
    stop = total;
    closed = 1'b1;
    if ($urandom_range(99) < 15) begin
      stop = $urandom_range(1, total);
      closed = 1'($urandom_range(1));
    end
    for (n = 0; n < stop; n++) begin
      ink = dark_col[n % cols] && ($urandom_range(3) != 0);
      if ($urandom_range(99) < 8)
        drive_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), closed && (n == stop - 1));
      else
        drive_pixel(shade(ink), shade(ink), shade(ink), closed && (n == stop - 1));
    end
  endtask

  // ---------------------------------------------------------------------
  // Directed table.
  // ---------------------------------------------------------------------
  plan_row_t plan [$];

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '{is_reg: 1'b1, reg_idx: idx, reg_val: val, default: '0};
    return row;
  endfunction

  function automatic plan_row_t pix(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                    logic fe);
    plan_row_t row;
    row = '{red_v: r, green_v: g, blue_v: b, last_px: fe, default: '0};
    return row;
  endfunction

  // Frame-end pixel whose image yields exactly one item.
  function automatic plan_row_t pin_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic [7:0] s, logic [7:0] e, logic f);
    plan_row_t row;
    row = pix(r, g, b, 1'b1);
    row.pinned = 1'b1;
    row.pinned_run = '{first_col: s, last_col: e, found: f, closing: 1'b1};
    return row;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] w_next, t_next, m_next;
    int unsigned           phase, pick;

    // reset defaults: a lone ink column is narrower than the minimum of 3
    plan.push_back(pin_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    plan.push_back(reg_row(REG_IMAGE_WIDTH, 9'd4));
    plan.push_back(reg_row(REG_MIN_RUN_WIDTH, 9'd1));
    // one row, inked columns 1..2
    plan.push_back(pix(8'd255, 8'd255, 8'd255, 1'b0));
    plan.push_back(pix(8'd0, 8'd0, 8'd0, 1'b0));
    plan.push_back(pix(8'd0, 8'd0, 8'd0, 1'b0));
    plan.push_back(pin_row(8'd255, 8'd255, 8'd255, 8'd1, 8'd2, 1'b1));
    // mean right at the threshold, row wrap, frame end mid row
    plan.push_back(pix(8'd200, 8'd200, 8'd199, 1'b0));
    plan.push_back(pix(8'd200, 8'd200, 8'd200, 1'b0));
    plan.push_back(pix(8'd201, 8'd200, 8'd199, 1'b0));
    plan.push_back(pix(8'd255, 8'd255, 8'd255, 1'b0));
    plan.push_back(pix(8'd255, 8'd255, 8'd92, 1'b0));
    plan.push_back(pix(8'd0, 8'd255, 8'd255, 1'b1));
    // threshold 0: nothing is ink
    plan.push_back(reg_row(REG_INK_THRESHOLD, 9'd0));
    plan.push_back(pin_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    // threshold past 255: everything is ink
    plan.push_back(reg_row(REG_INK_THRESHOLD, 9'd511));
    plan.push_back(pin_row(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1));
    // width 0 acts as a single column
    plan.push_back(reg_row(REG_INK_THRESHOLD, 9'd200));
    plan.push_back(reg_row(REG_IMAGE_WIDTH, 9'd0));
    plan.push_back(pin_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    // minimum wider than the image: the full-width run is not reported
    plan.push_back(reg_row(REG_IMAGE_WIDTH, 9'd4));
    plan.push_back(reg_row(REG_MIN_RUN_WIDTH, 9'd5));
    plan.push_back(pix(8'd0, 8'd0, 8'd0, 1'b0));
    plan.push_back(pix(8'd0, 8'd0, 8'd0, 1'b0));
    plan.push_back(pix(8'd0, 8'd0, 8'd0, 1'b0));
    plan.push_back(pin_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    // minimum 0 behaves as 1
    plan.push_back(reg_row(REG_MIN_RUN_WIDTH, 9'd0));
    plan.push_back(pin_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    // narrow the width under a half-written image: next pixel lands in column 0
    plan.push_back(reg_row(REG_IMAGE_WIDTH, 9'd8));
    plan.push_back(reg_row(REG_MIN_RUN_WIDTH, 9'd2));
    plan.push_back(pix(8'd0, 8'd0, 8'd0, 1'b0));
    plan.push_back(pix(8'd0, 8'd0, 8'd0, 1'b0));
    plan.push_back(pix(8'd255, 8'd255, 8'd255, 1'b0));
    plan.push_back(pix(8'd0, 8'd0, 8'd0, 1'b0));
    plan.push_back(pix(8'd255, 8'd255, 8'd255, 1'b0));
    plan.push_back(reg_row(REG_IMAGE_WIDTH, 9'd3));
    plan.push_back(pix(8'd255, 8'd255, 8'd255, 1'b1));

    // Reset once; register writes are fine during the clearing pass, pixels
    // simply wait for in_ready.
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else drive_pixel(plan[i].red_v, plan[i].green_v, plan[i].blue_v, plan[i].last_px,
                       plan[i].pinned, plan[i].pinned_run);
    end

    // Random phases. Phase 0 is a crowded image with more runs than can be
    // reported, phase 1 one wide image; the rest are small images under
    // random settings. Phases 2..5 run without any idling.
    phase = 0;
    while (pixels_sent < PIXEL_BUDGET) begin
      calm = (phase >= 2 && phase <= 5);
      if (phase == 0) begin
        // width above the column count clamps to 256; every even column up to 130 inked
        write_reg(REG_IMAGE_WIDTH, 9'd511);
        write_reg(REG_INK_THRESHOLD, 9'd128);
        write_reg(REG_MIN_RUN_WIDTH, 9'd1);
        for (int x = 0; x <= 130; x++)
          drive_pixel(shade(x % 2 == 0), shade(x % 2 == 0), shade(x % 2 == 0), x == 130);
      end else if (phase == 1) begin
        write_reg(REG_IMAGE_WIDTH, 9'd200);
        write_reg(REG_MIN_RUN_WIDTH, 9'd2);
        random_frame(200, 1);
      end else begin
        w_next = width_reg;
        t_next = thresh_reg;
        m_next = min_reg;
        if ($urandom_range(99) < 70) begin
          pick = $urandom_range(99);
          w_next = (pick < 8) ? 9'd0 : (pick < 16) ? 9'd1 : 9'($urandom_range(2, 24));
          write_reg(REG_IMAGE_WIDTH, w_next);
        end
        if ($urandom_range(99) < 70) begin
          pick = $urandom_range(99);
          t_next = (pick < 10) ? 9'd0 : (pick < 20) ? 9'd256 : (pick < 25) ? 9'd511 :
                   (pick < 40) ? 9'($urandom_range(511)) : 9'($urandom_range(80, 220));
          write_reg(REG_INK_THRESHOLD, t_next);
        end
        if ($urandom_range(99) < 70) begin
          pick = $urandom_range(99);
          m_next = (pick < 10) ? 9'd0 :
                   (pick < 15) ? 9'(eff_cols(w_next) + 1) :
                   (pick < 20) ? 9'd511 : 9'($urandom_range(1, 4));
          write_reg(REG_MIN_RUN_WIDTH, m_next);
        end
        repeat ($urandom_range(1, 4)) random_frame(eff_cols(w_next), $urandom_range(1, 2));
      end
      if (dirty) settle();
      phase++;
    end

    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    calm = 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (SWEEP_CYCLES) @(posedge clk);

    $display("covered %0d pixels in %0d images over %0d phases, %0d register writes",
             pixels_sent, frames_seen, phase, reg_writes);
    $display("checked %0d run items field by field, %0d mismatches", runs_checked,
             failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
